// ===== hdl/mf_pkg.sv =====
// Shared types and constants of the median filter.
// Used by the interfaces, the rank cells and the top level.
`timescale 1ns / 1ps

package mf_pkg;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_WINDOW_SIZE  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int WS_W        = 3;
    localparam int IW_W        = 11;
    localparam int IH_W        = 12;
    localparam int PIX_W       = 8;

    // Output queue that absorbs every item still in the pipeline.
    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_AW     = 4;
    localparam int PEND_W      = 5;

    // Sideband that travels with an item down the rank cells.
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             inner;
        logic             frame_end;
        logic [PIX_W-1:0] border;
    } t_side;

    // Rank of the median, counted from zero, for half window h.
    function automatic logic [6:0] mf_kinit(input logic [2:0] h);
        logic [3:0] side;
        logic [7:0] n;
        side = {h, 1'b1};
        n = 8'(side) * 8'(side);
        return n[7:1];
    endfunction

endpackage

// ===== hdl/mf_in_if.sv =====
// Input channel of the median filter: valid, ready, op and pixel.
// Depends on mf_pkg for the pixel width.
`timescale 1ns / 1ps

interface mf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [mf_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

// ===== hdl/mf_out_if.sv =====
// Output channel of the median filter: valid, ready, pixel and frame end.
// Depends on mf_pkg for the pixel width.
`timescale 1ns / 1ps

interface mf_out_if;
    logic                     valid;
    logic                     ready;
    logic [mf_pkg::PIX_W-1:0] pixel_out;
    logic                     frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== hdl/mf_line_ram.sv =====
// One row of the line store: one write port and two registered read ports.
// No dependencies; reads return the old data on a same-address write.
`timescale 1ns / 1ps

module mf_line_ram #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [7:0]    o_rdata_a,
    output logic [7:0]    o_rdata_b
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata_a;
    logic [7:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/mf_rank_cell.sv =====
// One bit cell of the median chain: settles one result bit, MSB first.
// Depends on mf_pkg for the sideband struct.
`timescale 1ns / 1ps

module mf_rank_cell #(
    parameter int N = 49,
    parameter int BIT = 7,
    localparam int KW = $clog2(N)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [N-1:0][7:0]    i_val,
    input  logic [N-1:0]         i_cand,
    input  logic [KW-1:0]        i_k,
    input  logic [7:0]           i_res,
    input  mf_pkg::t_side        i_side,
    output logic [N-1:0][7:0]    o_val,
    output logic [N-1:0]         o_cand,
    output logic [KW-1:0]        o_k,
    output logic [7:0]           o_res,
    output mf_pkg::t_side        o_side
);

    localparam int CNTW = $clog2(N + 1);

    logic [N-1:0]      bitvec;
    logic [CNTW-1:0]   zeros;
    logic              one;
    logic [7:0]        res_d;

    logic [N-1:0][7:0] r_val;
    logic [N-1:0]      r_cand;
    logic [KW-1:0]     r_k;
    logic [7:0]        r_res;
    mf_pkg::t_side     r_side;

    // Count the candidates that have a zero in this bit; if the rank lies
    // beyond them the median has a one here.
    always_comb begin
        zeros = '0;
        for (int j = 0; j < N; j++) begin
            bitvec[j] = i_val[j][BIT];
            zeros = zeros + CNTW'(i_cand[j] & ~i_val[j][BIT]);
        end
        one = !(CNTW'(i_k) < zeros);
        res_d = i_res;
        res_d[BIT] = one;
    end

    always_ff @(posedge i_clk) begin
        r_val  <= i_val;
        r_cand <= one ? (i_cand & bitvec) : (i_cand & ~bitvec);
        r_k    <= one ? KW'(CNTW'(i_k) - zeros) : i_k;
        r_res  <= res_d;
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_val  = r_val;
    assign o_cand = r_cand;
    assign o_k    = r_k;
    assign o_res  = r_res;
    assign o_side = r_side;

endmodule

// ===== hdl/median_filter_2d.sv =====
// Streaming 2-D median filter: line store, window array and bit-cell chain.
// A result enters the output queue once the first stage, the window array and
// the eight bit cells have registered it; results lag inputs by h*W+h items.
// Throughput is one item per cycle while fewer than FIFO_DEPTH items are pending,
// set by the one-pixel-per-cycle line store and the eight pipelined bit cells.
// Synchronous active-low reset clears counters, valids and queue, not line store.
`timescale 1ns / 1ps

module median_filter_2d #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mf_in_if.sink                         i_pix,
    mf_out_if.source                      o_pix
);

    localparam int LS   = MAX_WINDOW - 1;
    localparam int N    = MAX_WINDOW * MAX_WINDOW;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > mf_pkg::IW_W) ? WW : mf_pkg::IW_W;
    localparam int CAP  = (MAX_WINDOW - 1) | 1;
    localparam int HMAX = CAP / 2;
    localparam int LW   = $clog2(HMAX * MAX_WIDTH + HMAX + 1);
    localparam int SW   = $clog2(LS);
    localparam int KW   = $clog2(N);
    localparam int RW   = mf_pkg::IH_W;

    // Configuration.
    logic [mf_pkg::WS_W-1:0] r_ws;
    logic [mf_pkg::IW_W-1:0] r_iw;
    logic [mf_pkg::IH_W-1:0] r_ih;

    logic [2:0]    ws_odd;
    logic [2:0]    h;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] ht;
    logic [LW-1:0] lag;

    always_comb begin
        ws_odd = r_ws | 3'd1;
        h = ({1'b0, ws_odd} > 4'(CAP)) ? 3'(CAP / 2) : (ws_odd >> 1);
        if (r_iw == '0) begin
            w_eff = WW'(1);
        end else if (CMPW'(r_iw) > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_iw);
        end
        ht  = (r_ih == '0) ? RW'(1) : r_ih;
        lag = LW'(h) * LW'(w_eff) + LW'(h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= 3'd3;
            r_iw <= 11'd640;
            r_ih <= 12'd480;
        end else if (i_cfg_we) begin
            unique case (mf_pkg::t_cfg_idx'(i_cfg_idx))
                mf_pkg::CFG_WINDOW_SIZE:  r_ws <= i_cfg_data[mf_pkg::WS_W-1:0];
                mf_pkg::CFG_IMAGE_WIDTH:  r_iw <= i_cfg_data[mf_pkg::IW_W-1:0];
                mf_pkg::CFG_IMAGE_HEIGHT: r_ih <= i_cfg_data[mf_pkg::IH_W-1:0];
                default: ;
            endcase
        end
    end

    // Position counters and handshake.
    logic [RW-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [SW-1:0] r_in_slot, n_in_slot, r_out_slot, n_out_slot;
    logic [LW-1:0] r_lead, n_lead;
    logic          r_drain, n_drain;
    logic [mf_pkg::PEND_W-1:0] r_pend;

    logic          acc, is_pix, start, emit, inner, fe;
    logic          in_last_col, in_last_row, out_last_col, out_last_row;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic [SW-1:0] cur_slot;
    logic [LS-1:0] row_ok;

    assign i_pix.ready = (r_pend < mf_pkg::PEND_W'(mf_pkg::FIFO_DEPTH));
    assign acc    = i_pix.valid && i_pix.ready;
    assign is_pix = (i_pix.op == mf_pkg::OP_PIXEL);
    assign start  = (r_in_row == '0) && (r_in_col == '0);

    always_comb begin
        // A new frame drops whatever output of the previous one is left.
        if (is_pix && start) begin
            cur_row  = '0;
            cur_col  = '0;
            cur_slot = '0;
        end else begin
            cur_row  = r_out_row;
            cur_col  = r_out_col;
            cur_slot = r_out_slot;
        end
        emit = is_pix ? (r_lead >= lag) : r_drain;
        inner = (cur_row >= RW'(h)) && ((RW + 1)'(cur_row) + (RW + 1)'(h) < (RW + 1)'(ht))
             && (cur_col >= CW'(h))
             && ((WW + 1)'(cur_col) + (WW + 1)'(h) < (WW + 1)'(w_eff));
        out_last_col = (WW'(cur_col) == w_eff - WW'(1));
        out_last_row = (cur_row == ht - RW'(1));
        fe = out_last_col && out_last_row;
        in_last_col = (WW'(r_in_col) == w_eff - WW'(1));
        in_last_row = (r_in_row == ht - RW'(1));
        for (int r = 0; r < LS; r++) begin
            row_ok[r] = (r_in_row >= RW'(LS - r));
        end
    end

    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_in_slot  = r_in_slot;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_slot = r_out_slot;
        n_lead     = r_lead;
        n_drain    = r_drain;
        if (acc && (is_pix || r_drain)) begin
            n_out_row  = cur_row;
            n_out_col  = cur_col;
            n_out_slot = cur_slot;
            if (emit) begin
                if (out_last_col) begin
                    n_out_col = '0;
                    if (out_last_row) begin
                        n_out_row  = '0;
                        n_out_slot = '0;
                    end else begin
                        n_out_row  = cur_row + RW'(1);
                        n_out_slot = (cur_slot == SW'(LS - 1)) ? '0 : cur_slot + SW'(1);
                    end
                end else begin
                    n_out_col = cur_col + CW'(1);
                end
            end
            if (is_pix) begin
                if (start) begin
                    n_drain = 1'b0;
                end
                if (r_lead < lag) begin
                    n_lead = r_lead + LW'(1);
                end
                if (in_last_col) begin
                    n_in_col = '0;
                    if (in_last_row) begin
                        n_in_row  = '0;
                        n_in_slot = '0;
                        n_lead    = '0;
                        n_drain   = !(emit && fe);
                    end else begin
                        n_in_row  = r_in_row + RW'(1);
                        n_in_slot = (r_in_slot == SW'(LS - 1)) ? '0 : r_in_slot + SW'(1);
                    end
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
            end else if (fe) begin
                n_drain = 1'b0;
            end
        end
        if (i_cfg_we) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_in_slot  = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_out_slot = '0;
            n_lead     = '0;
            n_drain    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
            r_lead     <= '0;
            r_drain    <= 1'b0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_slot <= n_out_slot;
            r_lead     <= n_lead;
            r_drain    <= n_drain;
        end
    end

    // Line store: one bank per stored row.
    logic [7:0] rd_a [LS];
    logic [7:0] rd_b [LS];

    for (genvar b = 0; b < LS; b++) begin : g_bank
        mf_line_ram #(.DEPTH(MAX_WIDTH)) u_ram (
            .i_clk     (i_clk),
            .i_we      (acc && is_pix && (r_in_slot == SW'(b))),
            .i_waddr   (r_in_col),
            .i_wdata   (i_pix.pixel_in),
            .i_raddr_a (r_in_col),
            .i_raddr_b (cur_col),
            .o_rdata_a (rd_a[b]),
            .o_rdata_b (rd_b[b])
        );
    end

    // First stage: item info waits for the line store read.
    logic          r_s1_valid, r_s1_is_pix, r_s1_emit, r_s1_inner, r_s1_fe;
    logic [7:0]    r_s1_pix;
    logic [SW-1:0] r_s1_in_slot, r_s1_out_slot;
    logic [LS-1:0] r_s1_row_ok;

    always_ff @(posedge i_clk) begin
        r_s1_is_pix   <= is_pix;
        r_s1_emit     <= emit;
        r_s1_inner    <= inner;
        r_s1_fe       <= fe;
        r_s1_pix      <= i_pix.pixel_in;
        r_s1_in_slot  <= r_in_slot;
        r_s1_out_slot <= cur_slot;
        r_s1_row_ok   <= row_ok;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    // Window array: every column shifts left, the new column enters right.
    logic [7:0]    r_win [MAX_WINDOW][MAX_WINDOW];
    logic [7:0]    new_col [MAX_WINDOW];
    logic [SW:0]   bank_sel;
    mf_pkg::t_side r_s2_side;

    always_comb begin
        for (int r = 0; r < LS; r++) begin
            bank_sel = (SW + 1)'(r_s1_in_slot) + (SW + 1)'(r);
            if (bank_sel >= (SW + 1)'(LS)) begin
                bank_sel = bank_sel - (SW + 1)'(LS);
            end
            new_col[r] = r_s1_row_ok[r] ? rd_a[bank_sel[SW-1:0]] : 8'd0;
        end
        new_col[LS] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_is_pix) begin
            for (int r = 0; r < MAX_WINDOW; r++) begin
                for (int c = 0; c < MAX_WINDOW - 1; c++) begin
                    r_win[r][c] <= r_win[r][c + 1];
                end
                r_win[r][MAX_WINDOW - 1] <= new_col[r];
            end
        end
        r_s2_side.emit      <= r_s1_emit;
        r_s2_side.inner     <= r_s1_inner;
        r_s2_side.frame_end <= r_s1_fe;
        r_s2_side.border    <= rd_b[r_s1_out_slot];
        if (!i_rst_n) begin
            r_s2_side.valid <= 1'b0;
        end else begin
            r_s2_side.valid <= r_s1_valid;
        end
    end

    // Chain of bit cells.
    logic [N-1:0][7:0] c_val  [9];
    logic [N-1:0]      c_cand [9];
    logic [KW-1:0]     c_k    [9];
    logic [7:0]        c_res  [9];
    mf_pkg::t_side     c_side [9];
    logic [6:0]        k_init;
    logic [3:0]        base;

    always_comb begin
        k_init = mf_pkg::mf_kinit(h);
        base = 4'(MAX_WINDOW - 1) - {h, 1'b0};
        for (int r = 0; r < MAX_WINDOW; r++) begin
            for (int c = 0; c < MAX_WINDOW; c++) begin
                c_val[0][r * MAX_WINDOW + c]  = r_win[r][c];
                c_cand[0][r * MAX_WINDOW + c] = (4'(r) >= base) && (4'(c) >= base);
            end
        end
        c_k[0]    = k_init[KW-1:0];
        c_res[0]  = 8'd0;
        c_side[0] = r_s2_side;
    end

    for (genvar s = 0; s < 8; s++) begin : g_cell
        mf_rank_cell #(.N(N), .BIT(7 - s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_val   (c_val[s]),
            .i_cand  (c_cand[s]),
            .i_k     (c_k[s]),
            .i_res   (c_res[s]),
            .i_side  (c_side[s]),
            .o_val   (c_val[s + 1]),
            .o_cand  (c_cand[s + 1]),
            .o_k     (c_k[s + 1]),
            .o_res   (c_res[s + 1]),
            .o_side  (c_side[s + 1])
        );
    end

    // Output queue; r_pend counts every item accepted and not yet finished.
    logic [8:0]                 r_fifo [mf_pkg::FIFO_DEPTH];
    logic [mf_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [mf_pkg::PEND_W-1:0]  r_cnt;
    logic                       push, pop, drop;
    logic [7:0]                 res_pix;

    assign push    = c_side[8].valid && c_side[8].emit;
    assign drop    = c_side[8].valid && !c_side[8].emit;
    assign pop     = o_pix.valid && o_pix.ready;
    assign res_pix = c_side[8].inner ? c_res[8] : c_side[8].border;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr] <= {c_side[8].frame_end, res_pix};
        end
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + mf_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + mf_pkg::FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + mf_pkg::PEND_W'(push) - mf_pkg::PEND_W'(pop);
            r_pend <= r_pend + mf_pkg::PEND_W'(acc) - mf_pkg::PEND_W'(pop)
                    - mf_pkg::PEND_W'(drop);
        end
    end

    assign o_pix.valid     = (r_cnt != '0);
    assign o_pix.pixel_out = r_fifo[r_rd][7:0];
    assign o_pix.frame_end = r_fifo[r_rd][8];

endmodule

// ===== hdl/mf_checker.sv =====
// Port-level checks of the median filter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module mf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    logic [31:0] r_bal;

    // Items accepted at the input and not yet taken at the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= '0;
        end else begin
            r_bal <= r_bal + 32'(i_in_valid && i_in_ready) - 32'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_bal != 32'd0)
        else $error("output item without a pending input item");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input blocked while no result waits");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind median_filter_2d mf_checker u_mf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready)
);
